@@ src/sync_frame_checksum_parser_assert.svh @@
// assertion macros used by the checker
`ifndef SYNC_FRAME_CHECKSUM_PARSER_ASSERT_SVH
`define SYNC_FRAME_CHECKSUM_PARSER_ASSERT_SVH

// same-cycle implication
`define SFCP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("sfcp check failed");

// next-cycle implication
`define SFCP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("sfcp check failed");

`endif

@@ src/sfcp_pkg.sv @@
`default_nettype none
package sfcp_pkg;

	localparam int FRAME_BYTES = 34;
	localparam int SYNC_COUNT  = 4;
	localparam int MAX_WORDS   = 64;

	localparam int BYTE_W  = 8;
	localparam int VALUE_W = 16;
	localparam int INDEX_W = 6;

	localparam int PAY_START = SYNC_COUNT + 3;
	localparam int CHECK_POS = FRAME_BYTES - 1;
	localparam int PAY_LEN   = (CHECK_POS > PAY_START) ? (CHECK_POS - PAY_START) : 0;
	localparam int NUM_WORDS = ((PAY_LEN / 2) > MAX_WORDS) ? MAX_WORDS : (PAY_LEN / 2);
	localparam bit HAS_WORDS = (NUM_WORDS > 0);
	localparam int MEM_BYTES = HAS_WORDS ? (2 * NUM_WORDS) : 2;
	localparam int ADDR_W    = $clog2(MEM_BYTES);
	localparam int POS_MAX   = (CHECK_POS > PAY_START) ? CHECK_POS : PAY_START;
	localparam int POS_W     = $clog2(POS_MAX + 1);
	localparam int LAST_IDX  = HAS_WORDS ? (NUM_WORDS - 1) : 0;

	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [INDEX_W-1:0] index_t;

	localparam pos_t POS_SYNC  = pos_t'(SYNC_COUNT);
	localparam pos_t POS_DEV   = pos_t'(SYNC_COUNT + 1);
	localparam pos_t POS_MSG   = pos_t'(SYNC_COUNT + 2);
	localparam pos_t POS_PAY   = pos_t'(PAY_START);
	localparam pos_t POS_CHECK = pos_t'(CHECK_POS);
	localparam pos_t POS_MEM   = pos_t'(MEM_BYTES);

	localparam byte_t  FRAME_LEN_BYTE = byte_t'(FRAME_BYTES % 256);
	localparam index_t LAST_INDEX     = index_t'(LAST_IDX);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_ID = 2'd2;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		byte_t wdata;
		logic  start;
	} wr_t;

endpackage
`default_nettype wire

@@ src/sfcp_ifs.sv @@
`default_nettype none
interface sfcp_byte_if;
	logic                       valid;
	logic                       ready;
	logic [sfcp_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfcp_word_if;
	logic                               valid;
	logic                               ready;
	logic signed [sfcp_pkg::VALUE_W-1:0] word_value;
	logic [sfcp_pkg::INDEX_W-1:0]        word_index;
	logic                               last_word;

	modport source (output valid, output word_value, output word_index, output last_word,
		input ready);
	modport sink (input valid, input word_value, input word_index, input last_word,
		output ready);
endinterface
`default_nettype wire

@@ src/sfcp_emitter.sv @@
`default_nettype none
module sfcp_emitter (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sfcp_pkg::wr_t       wr,
	output logic                busy,
	sfcp_word_if.source         words
);

	typedef enum logic [3:0] {
		E_IDLE = 4'b0001,
		E_HI   = 4'b0010,
		E_LO   = 4'b0100,
		E_PUT  = 4'b1000
	} emit_state_t;

	emit_state_t state_q;
	sfcp_pkg::index_t k_q;
	sfcp_pkg::byte_t hi_q;
	sfcp_pkg::byte_t rdata_q;
	sfcp_pkg::byte_t mem [sfcp_pkg::MEM_BYTES];

	logic re;
	sfcp_pkg::addr_t raddr;
	logic out_free;
	logic out_valid_q;
	logic signed [sfcp_pkg::VALUE_W-1:0] out_value_q;
	sfcp_pkg::index_t out_index_q;
	logic out_last_q;
	logic is_last;

	assign busy     = (state_q != E_IDLE);
	assign out_free = !out_valid_q || words.ready;
	assign is_last  = (k_q == sfcp_pkg::LAST_INDEX);
	assign re       = (state_q == E_HI) || (state_q == E_LO);
	assign raddr    = sfcp_pkg::addr_t'({k_q, (state_q == E_LO)});

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.waddr] <= wr.wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				E_IDLE: begin
					k_q <= '0;
					if (wr.start) begin
						state_q <= E_HI;
					end
				end
				E_HI: state_q <= E_LO;
				E_LO: state_q <= E_PUT;
				E_PUT: begin
					if (out_free) begin
						if (is_last) begin
							state_q <= E_IDLE;
						end else begin
							k_q     <= k_q + sfcp_pkg::index_t'(1);
							state_q <= E_HI;
						end
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_LO) begin
			hi_q <= rdata_q;
		end
		if (state_q == E_PUT && out_free) begin
			out_value_q <= $signed({hi_q, rdata_q});
			out_index_q <= k_q;
			out_last_q  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == E_PUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (words.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign words.valid      = out_valid_q;
	assign words.word_value = out_value_q;
	assign words.word_index = out_index_q;
	assign words.last_word  = out_last_q;

endmodule
`default_nettype wire

@@ src/sync_frame_checksum_parser.sv @@
// channel   dir  beat payload                              handshake
// rx        in   rx_byte[7:0]                              valid / ready
// words     out  word_value[15:0] s, word_index[5:0],      valid / ready
//                last_word
// cfg       in   cfg_index[1:0], cfg_data[7:0]             cfg_we, no wait
//
// one rx beat per cycle while no frame is being emitted
// a frame that passes its checksum byte holds rx off while its words are read
// from the payload ram one word at a time (one ram read port, hi then lo byte),
// 13 words at the default frame size, held off longer while words is stalled
// rx is taken again as soon as the last word sits in the output register
// arst_n resets the parser and the config registers; no ram clearing pass
`default_nettype none
module sync_frame_checksum_parser (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [sfcp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [sfcp_pkg::BYTE_W-1:0]          cfg_data,
	sfcp_byte_if.sink                           rx,
	sfcp_word_if.source                         words
);

	typedef enum logic [3:0] {
		PH_SYNC    = 4'b0001,
		PH_HEADER  = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_CHECK   = 4'b1000
	} phase_t;

	phase_t phase_q, phase_d;
	sfcp_pkg::pos_t pos_q, pos_d, pos_inc, pay_off;
	sfcp_pkg::byte_t sum_q, sum_d, sum_inc;
	sfcp_pkg::byte_t sync_value_q, device_id_q, message_id_q;
	sfcp_pkg::wr_t wr;
	logic busy;
	logic fire;
	logic header_ok;
	sfcp_pkg::byte_t b;

	assign b        = rx.rx_byte;
	assign rx.ready = !busy;
	assign fire     = rx.valid && !busy;
	assign pos_inc  = pos_q + sfcp_pkg::pos_t'(1);
	assign sum_inc  = sum_q + b;
	assign pay_off  = pos_q - sfcp_pkg::POS_PAY;

	assign header_ok = (pos_q == sfcp_pkg::POS_SYNC && b == sfcp_pkg::FRAME_LEN_BYTE)
		|| (pos_q == sfcp_pkg::POS_DEV && b == device_id_q)
		|| (pos_q == sfcp_pkg::POS_MSG && b == message_id_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q <= 8'hff;
			device_id_q  <= '0;
			message_id_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sfcp_pkg::CFG_SYNC_VALUE: sync_value_q <= cfg_data;
				sfcp_pkg::CFG_DEVICE_ID:  device_id_q  <= cfg_data;
				sfcp_pkg::CFG_MESSAGE_ID: message_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		wr.we     = 1'b0;
		wr.waddr  = sfcp_pkg::addr_t'(pay_off);
		wr.wdata  = b;
		wr.start  = 1'b0;
		if (fire) begin
			case (phase_q)
				PH_SYNC: begin
					if (b == sync_value_q) begin
						pos_d = pos_inc;
						sum_d = sum_inc;
						if (pos_inc >= sfcp_pkg::POS_SYNC) begin
							phase_d = PH_HEADER;
						end
					end else begin
						phase_d = PH_SYNC;
						pos_d   = '0;
						sum_d   = '0;
					end
				end
				PH_HEADER: begin
					if (header_ok) begin
						pos_d = pos_inc;
						sum_d = sum_inc;
						if (pos_inc >= sfcp_pkg::POS_PAY) begin
							phase_d = (pos_inc >= sfcp_pkg::POS_CHECK) ? PH_CHECK : PH_PAYLOAD;
						end
					end else begin
						phase_d = PH_SYNC;
						pos_d   = '0;
						sum_d   = '0;
					end
				end
				PH_PAYLOAD: begin
					pos_d = pos_inc;
					sum_d = sum_inc;
					wr.we = (pay_off < sfcp_pkg::POS_MEM);
					if (pos_inc >= sfcp_pkg::POS_CHECK) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					wr.start = sfcp_pkg::HAS_WORDS && (b == sum_q);
					phase_d  = PH_SYNC;
					pos_d    = '0;
					sum_d    = '0;
				end
				default: begin
					phase_d = PH_SYNC;
					pos_d   = '0;
					sum_d   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			pos_q   <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
		end
	end

	sfcp_emitter u_emitter (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.busy   (busy),
		.words  (words)
	);

endmodule
`default_nettype wire

@@ src/sfcp_checker.sv @@
`default_nettype none
`include "sync_frame_checksum_parser_assert.svh"
module sfcp_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 rx_ready,
	input wire                                 word_valid,
	input wire                                 word_ready,
	input wire signed [sfcp_pkg::VALUE_W-1:0]  word_value,
	input wire [sfcp_pkg::INDEX_W-1:0]         word_index,
	input wire                                 last_word
);

	`SFCP_ASSERT_NEXT(a_word_hold, clk, arst_n, word_valid && !word_ready, word_valid && $stable(word_value) && $stable(word_index) && $stable(last_word))

	`SFCP_ASSERT_NOW(a_last_index, clk, arst_n, word_valid && last_word, word_index == sfcp_pkg::LAST_INDEX)

	`SFCP_ASSERT_NOW(a_rx_held_mid_frame, clk, arst_n, word_valid && !last_word, !rx_ready)

	`SFCP_ASSERT_NEXT(a_rx_held_after_beat, clk, arst_n, word_valid && word_ready && !last_word, !rx_ready || (word_valid && last_word))

endmodule

bind sync_frame_checksum_parser sfcp_checker u_sfcp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rx_ready   (rx.ready),
	.word_valid (words.valid),
	.word_ready (words.ready),
	.word_value (words.word_value),
	.word_index (words.word_index),
	.last_word  (words.last_word)
);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
module tb;
	import sfcp_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 11;
	localparam int STORE_DEPTH  = 136;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_BYTES  = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_PAYLOAD, PH_CHECK} parse_phase_e;

	typedef enum int {
		FR_GOOD, FR_BAD_SUM, FR_BAD_LEN, FR_BAD_DEV, FR_BAD_MSG,
		FR_SYNC_BREAK, FR_LONG_SYNC, FR_NOISE
	} frame_kind_e;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [INDEX_W-1:0]        index;
		logic                      last_word;
	} word_beat_t;

	typedef struct {
		frame_kind_e     kind;
		bit              fixed;
		byte_t           hi;
		byte_t           lo;
		int              n_words;
		bit              typed;
		logic [VALUE_W-1:0] value;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	byte_t cfg_data;

	sfcp_byte_if rx_if();
	sfcp_word_if words_if();

	sync_frame_checksum_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_if),
		.words     (words_if)
	);

	// parser mirror
	byte_t sync_val;
	byte_t dev_id;
	byte_t msg_id;
	parse_phase_e phase;
	logic [7:0] frame_pos;
	byte_t frame_sum;
	byte_t frame_mem [STORE_DEPTH];
	word_beat_t expected_words[$];

	int mismatches;
	int rx_beats;
	int word_beats;
	int frames_ok;
	int stall_cycles;
	int src_idle_pct;
	int snk_idle_pct;

	int row_word_count;
	int row_value_bad;
	bit row_value_on;
	logic [VALUE_W-1:0] row_value;

	dir_row_t dir_rows [11] = '{
		'{FR_GOOD,       1'b1, 8'h00, 8'h00, NUM_WORDS, 1'b1, 16'h0000},
		'{FR_GOOD,       1'b1, 8'hFF, 8'hFF, NUM_WORDS, 1'b1, 16'hFFFF},
		'{FR_GOOD,       1'b1, 8'h7F, 8'hFF, NUM_WORDS, 1'b1, 16'h7FFF},
		'{FR_GOOD,       1'b1, 8'h80, 8'h00, NUM_WORDS, 1'b1, 16'h8000},
		'{FR_BAD_SUM,    1'b0, 8'h00, 8'h00, 0,         1'b0, 16'h0000},
		'{FR_BAD_LEN,    1'b0, 8'h00, 8'h00, 0,         1'b0, 16'h0000},
		'{FR_BAD_DEV,    1'b0, 8'h00, 8'h00, 0,         1'b0, 16'h0000},
		'{FR_BAD_MSG,    1'b0, 8'h00, 8'h00, 0,         1'b0, 16'h0000},
		'{FR_LONG_SYNC,  1'b0, 8'h00, 8'h00, 0,         1'b0, 16'h0000},
		'{FR_SYNC_BREAK, 1'b0, 8'h00, 8'h00, NUM_WORDS, 1'b0, 16'h0000},
		'{FR_NOISE,      1'b0, 8'h00, 8'h00, -1,        1'b0, 16'h0000}
	};

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(string what);
		$display("ERROR %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic void restart_hunt();
		phase = PH_HUNT;
		frame_pos = '0;
		frame_sum = '0;
	endfunction

	function automatic void take_byte(byte_t b);
		if (frame_pos < STORE_DEPTH)
			frame_mem[frame_pos] = b;
		frame_pos = frame_pos + 8'd1;
		frame_sum = frame_sum + b;
	endfunction

	function automatic void parse_rx_byte(byte_t b);
		bit hdr_ok;
		int pay_len;
		int n;
		int p;
		word_beat_t w;
		case (phase)
			PH_HUNT: begin
				if (b == sync_val) begin
					take_byte(b);
					if (frame_pos >= SYNC_COUNT)
						phase = PH_HEADER;
				end else begin
					restart_hunt();
				end
			end
			PH_HEADER: begin
				hdr_ok = (frame_pos == SYNC_COUNT && b == FRAME_LEN_BYTE)
					|| (frame_pos == SYNC_COUNT + 1 && b == dev_id)
					|| (frame_pos == SYNC_COUNT + 2 && b == msg_id);
				if (!hdr_ok) begin
					restart_hunt();
				end else begin
					take_byte(b);
					if (frame_pos >= PAY_START)
						phase = (frame_pos >= CHECK_POS) ? PH_CHECK : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				take_byte(b);
				if (frame_pos >= CHECK_POS)
					phase = PH_CHECK;
			end
			default: begin
				if (b == frame_sum) begin
					frames_ok++;
					pay_len = (CHECK_POS > PAY_START) ? (CHECK_POS - PAY_START) : 0;
					n = pay_len / 2;
					if (n > MAX_WORDS)
						n = MAX_WORDS;
					for (int k = 0; k < n; k++) begin
						p = PAY_START + 2 * k;
						w.value = {frame_mem[p], frame_mem[p + 1]};
						w.index = INDEX_W'(k);
						w.last_word = (k == n - 1);
						expected_words.push_back(w);
					end
				end
				restart_hunt();
			end
		endcase
	endfunction

	// beat monitor, word checker and watchdog
	always @(posedge clk) begin
		word_beat_t w;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (rx_if.valid && rx_if.ready) begin
				parse_rx_byte(rx_if.rx_byte);
				rx_beats++;
				moved = 1'b1;
			end
			if (words_if.valid && words_if.ready) begin
				moved = 1'b1;
				word_beats++;
				row_word_count++;
				if (row_value_on && words_if.word_value !== row_value)
					row_value_bad++;
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("word %0d index %0d with nothing expected",
						words_if.word_value, words_if.word_index));
				end else begin
					w = expected_words.pop_front();
					if (words_if.word_value !== w.value)
						report_mismatch($sformatf("word_value %0d, expected %0d (index %0d)",
							words_if.word_value, w.value, w.index));
					if (words_if.word_index !== w.index)
						report_mismatch($sformatf("word_index %0d, expected %0d",
							words_if.word_index, w.index));
					if (words_if.last_word !== w.last_word)
						report_mismatch($sformatf("last_word %0b, expected %0b (index %0d)",
							words_if.last_word, w.last_word, w.index));
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d words outstanding",
					STALL_LIMIT, expected_words.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			words_if.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// ready only moves at the rising edge, so it is sampled mid-cycle for the coming edge
	task automatic send_byte(byte_t b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		@(negedge clk);
		while (rx_if.ready !== 1'b1)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic wait_idle();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, byte_t d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			CFG_SYNC_VALUE: sync_val = d;
			CFG_DEVICE_ID:  dev_id = d;
			CFG_MESSAGE_ID: msg_id = d;
			default: ;
		endcase
	endtask

	// builds one frame (or a broken one) from the current register values and sends it
	task automatic send_frame(frame_kind_e kind, bit fixed, byte_t hi, byte_t lo, bit truncate);
		byte_t q[$];
		byte_t s;
		byte_t nz;
		int base;
		int cut;
		s = '0;
		nz = byte_t'($urandom_range(255, 1));
		if (kind == FR_NOISE) begin
			repeat ($urandom_range(12, 1))
				q.push_back(($urandom_range(3) == 0) ? sync_val : byte_t'($urandom));
			cut = q.size() - 1;
		end else begin
			if (kind == FR_SYNC_BREAK) begin
				repeat ($urandom_range(SYNC_COUNT - 1, 0)) q.push_back(sync_val);
				q.push_back(~sync_val);
			end
			if (kind == FR_LONG_SYNC)
				q.push_back(sync_val);
			base = q.size() + SYNC_COUNT;
			repeat (SYNC_COUNT) q.push_back(sync_val);
			q.push_back(FRAME_LEN_BYTE);
			q.push_back(dev_id);
			q.push_back(msg_id);
			for (int p = PAY_START; p < CHECK_POS; p++)
				q.push_back(fixed ? (((p - PAY_START) % 2 == 0) ? hi : lo) : byte_t'($urandom));
			for (int j = base - SYNC_COUNT; j < q.size(); j++)
				s = s + q[j];
			q.push_back((kind == FR_BAD_SUM) ? (s ^ nz) : s);
			case (kind)
				FR_BAD_LEN: q[base] = q[base] ^ nz;
				FR_BAD_DEV: q[base + 1] = q[base + 1] ^ nz;
				FR_BAD_MSG: q[base + 2] = q[base + 2] ^ nz;
				default: ;
			endcase
			case (kind)
				FR_BAD_LEN, FR_LONG_SYNC: cut = base;
				FR_BAD_DEV: cut = base + 1;
				FR_BAD_MSG: cut = base + 2;
				default: cut = q.size() - 1;
			endcase
			if (!truncate)
				cut = q.size() - 1;
		end
		for (int j = 0; j <= cut; j++)
			send_byte(q[j]);
	endtask

	initial begin
		frame_kind_e kind;
		int pick;
		int start_beats;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SYNC_VALUE;
		cfg_data = '0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		words_if.ready = 1'b0;
		sync_val = 8'hFF;
		dev_id = 8'h00;
		msg_id = 8'h00;
		restart_hunt();
		mismatches = 0;
		rx_beats = 0;
		word_beats = 0;
		frames_ok = 0;
		stall_cycles = 0;
		row_value_on = 1'b0;
		src_idle_pct = 23;
		snk_idle_pct = 61;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at reset register values
		foreach (dir_rows[i]) begin
			row_word_count = 0;
			row_value_bad = 0;
			row_value_on = dir_rows[i].typed;
			row_value = dir_rows[i].value;
			send_frame(dir_rows[i].kind, dir_rows[i].fixed, dir_rows[i].hi, dir_rows[i].lo, 1'b1);
			send_byte(~sync_val);
			wait_idle();
			if (dir_rows[i].n_words >= 0 && row_word_count != dir_rows[i].n_words)
				report_mismatch($sformatf("row %0d: %0d words, expected %0d",
					i, row_word_count, dir_rows[i].n_words));
			if (row_value_bad != 0)
				report_mismatch($sformatf("row %0d: %0d words off the fixed value",
					i, row_value_bad));
		end
		row_value_on = 1'b0;

		// random frames under three register settings and idling mixes
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 23;
					snk_idle_pct = 61;
					write_reg(CFG_SYNC_VALUE, 8'h00);
					write_reg(CFG_DEVICE_ID, 8'hFF);
					write_reg(CFG_MESSAGE_ID, 8'hFF);
				end
				1: begin
					src_idle_pct = 61;
					snk_idle_pct = 23;
					write_reg(CFG_SYNC_VALUE, FRAME_LEN_BYTE);
					write_reg(CFG_DEVICE_ID, byte_t'($urandom));
					write_reg(CFG_MESSAGE_ID, byte_t'($urandom));
					write_reg(CFG_UNUSED, byte_t'($urandom));
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
					write_reg(CFG_UNUSED, 8'hFF);
					write_reg(CFG_SYNC_VALUE, byte_t'($urandom));
					write_reg(CFG_DEVICE_ID, byte_t'($urandom));
					write_reg(CFG_MESSAGE_ID, byte_t'($urandom));
				end
			endcase
			cfg_we <= 1'b0;
			start_beats = rx_beats;
			while (rx_beats - start_beats < PHASE_BYTES) begin
				pick = $urandom_range(99);
				if (pick < 65)      kind = FR_GOOD;
				else if (pick < 72) kind = FR_BAD_SUM;
				else if (pick < 77) kind = FR_BAD_LEN;
				else if (pick < 82) kind = FR_BAD_DEV;
				else if (pick < 87) kind = FR_BAD_MSG;
				else if (pick < 91) kind = FR_SYNC_BREAK;
				else if (pick < 95) kind = FR_LONG_SYNC;
				else                kind = FR_NOISE;
				send_frame(kind, 1'b0, 8'h00, 8'h00, 1'($urandom_range(1)));
			end
			wait_idle();
		end

		$display("covered %0d rx beats and %0d word beats; %0d frames passed the checksum",
			rx_beats, word_beats, frames_ok);
		$display("register settings: reset values, low/high extremes, sync equal to length, random");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
